@@ rtl/ses_pkg.sv @@
// Shared types and constants of the Sobel edge stream unit.
package ses_pkg;

    // Field and register widths
    localparam int ROW_W  = 13;
    localparam int COL_W  = 12;
    localparam int PIX_W  = 24;
    localparam int LUMA_W = 8;
    localparam int OUT_W  = 32;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Line store depth default and the row clamp
    localparam int DEF_MAX_COLS = 2048;
    localparam logic [ROW_W-1:0] MAX_ROWS = 13'd4096;

    // Register reset values
    localparam logic [ROW_W-1:0] FRAME_ROWS_RST = 13'd1080;
    localparam logic [COL_W-1:0] FRAME_COLS_RST = 12'd1920;

    // Edge thresholds
    localparam logic [LUMA_W-1:0] EDGE_MAX = 8'd255;
    localparam logic [LUMA_W-1:0] EDGE_HI  = 8'd200;
    localparam logic [LUMA_W-1:0] EDGE_LO  = 8'd100;
    localparam logic [7:0]        ALPHA    = 8'hFF;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

    // 3x3 luma window, index row*3+col: rows two back, previous, current;
    // col 2 is the newest
    typedef logic [8:0][LUMA_W-1:0] window_t;

endpackage

@@ rtl/ses_line_store.sv @@
// Two-row luma line store: one word per column holds {two back, previous}.
module ses_line_store #(
    parameter int MAX_COLS = ses_pkg::DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
    output logic [2*ses_pkg::LUMA_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
    input  logic [2*ses_pkg::LUMA_W-1:0]  wr_data
);

    logic [2*ses_pkg::LUMA_W-1:0] mem [MAX_COLS];
    logic [2*ses_pkg::LUMA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ses_edge_calc.sv @@
// Sobel gradient, saturation, inversion and thresholding of one 3x3 window.
module ses_edge_calc (
    input  ses_pkg::window_t             win,
    input  logic                         interior,
    output logic [ses_pkg::LUMA_W-1:0]   grade_val
);

    logic signed [10:0] w [9];
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0] abs_gx;
    logic [10:0] abs_gy;
    logic [10:0] mag;
    logic [ses_pkg::LUMA_W-1:0] mag_sat;
    logic [ses_pkg::LUMA_W-1:0] inv;

    // widen the window taps to signed
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w[k] = $signed({3'b000, win[k]});
        end
    end

    // gradients: gx across columns, gy across rows (oldest row minus newest)
    assign gx = (w[2] - w[0]) + ((w[5] - w[3]) <<< 1) + (w[8] - w[6]);
    assign gy = (w[0] + (w[1] <<< 1) + w[2]) - (w[6] + (w[7] <<< 1) + w[8]);

    assign abs_gx = gx[10] ? 11'(-gx) : 11'(gx);
    assign abs_gy = gy[10] ? 11'(-gy) : 11'(gy);
    assign mag    = abs_gx + abs_gy;

    assign mag_sat = (mag > 11'(ses_pkg::EDGE_MAX)) ? ses_pkg::EDGE_MAX : mag[7:0];
    assign inv     = ses_pkg::EDGE_MAX - mag_sat;

    // threshold; border pixels give zero
    always_comb begin
        priority if (!interior) begin
            grade_val = '0;
        end else if (inv > ses_pkg::EDGE_HI) begin
            grade_val = ses_pkg::EDGE_MAX;
        end else if (inv < ses_pkg::EDGE_LO) begin
            grade_val = '0;
        end else begin
            grade_val = inv;
        end
    end

endmodule

@@ rtl/sobel_edge_stream_unit.sv @@
// Top level of the Sobel edge stream unit: scan control, luma, window, output.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_pixel_rgb[23:0]
//  m_       | m_valid / m_ready  | m_edge_pixel[31:0], m_end_of_row, m_end_of_frame
//  cfg_wr_  | cfg_wr_en          | cfg_wr_index, cfg_wr_data[12:0]
//
// One word per cycle in and out while m_ready is high.
// Per word: line store read on accept, luma/window/line store write in stage A,
// Sobel and threshold in stage B into the output register.
// Each stage holds its word only while the stage after it is full and stalled.
// aresetn (synchronous, active low) clears the scan position, the valids and
// the registers to 1080 rows by 1920 columns; the line store is not cleared.
module sobel_edge_stream_unit #(
    parameter int MAX_COLS = ses_pkg::DEF_MAX_COLS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [ses_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [ses_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ses_pkg::PIX_W-1:0]         s_pixel_rgb,
    // edge output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ses_pkg::OUT_W-1:0]         m_edge_pixel,
    output logic                              m_end_of_row,
    output logic                              m_end_of_frame
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int LW     = ses_pkg::LUMA_W;

    // luma of one RGB word
    function automatic logic [LW-1:0] rgb_to_luma(input logic [ses_pkg::PIX_W-1:0] rgb);
        logic [15:0] acc;
        acc = 16'(rgb[23:16]) * 16'd66 + 16'(rgb[15:8]) * 16'd129
            + 16'(rgb[7:0]) * 16'd25 + 16'd128;
        return acc[15:8] + 8'd16;
    endfunction

    // configuration and scan position
    logic [ses_pkg::ROW_W-1:0] frame_rows_reg;
    logic [ses_pkg::COL_W-1:0] frame_cols_reg;
    logic [ses_pkg::ROW_W-1:0] scan_row_reg, scan_row_next;
    logic [ses_pkg::COL_W-1:0] scan_col_reg, scan_col_next;
    logic [ses_pkg::ROW_W-1:0] rows_eff;
    logic [ses_pkg::COL_W-1:0] cols_eff;

    // stage A
    logic                      a_valid_reg;
    logic [ses_pkg::PIX_W-1:0] a_pixel_reg;
    logic [ADDR_W-1:0]         a_addr_reg;
    logic                      a_last_col_reg;
    logic                      a_last_row_reg;
    logic                      a_emit_reg;
    logic                      a_interior_reg;

    // stage B (window is its payload)
    logic                      b_valid_reg;
    logic                      b_emit_reg;
    logic                      b_interior_reg;
    logic                      b_eor_reg;
    logic                      b_eof_reg;
    ses_pkg::window_t          win_reg, win_next;

    // output register
    logic                      m_valid_reg;
    logic [LW-1:0]             m_edge_reg;
    logic                      m_eor_reg;
    logic                      m_eof_reg;

    // flow control
    logic out_free, b_free, a_free, accept, commit;
    logic last_col, last_row, emit, interior;

    // line store ports
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [2*LW-1:0]           rd_data;
    logic                      wr_en;
    logic [2*LW-1:0]           wr_data;
    logic [LW-1:0]             cur_luma;
    logic [LW-1:0]             grade_val;

    // stage advance: each stage moves when the next is empty or moving
    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_ready  = a_free;
    assign accept   = s_valid && a_free;
    assign commit   = a_valid_reg && b_free;

    // clamp the frame size to the line store and the row limit
    assign rows_eff = (frame_rows_reg > ses_pkg::MAX_ROWS) ? ses_pkg::MAX_ROWS
                                                           : frame_rows_reg;
    assign cols_eff = (32'(frame_cols_reg) > MAX_COLS) ? ses_pkg::COL_W'(MAX_COLS)
                                                       : frame_cols_reg;

    // step classification at the current scan position
    assign last_col = scan_col_reg >= cols_eff;
    assign last_row = scan_row_reg >= rows_eff;
    assign emit     = (scan_row_reg != '0) && (scan_col_reg != '0);
    assign interior = (scan_row_reg >= 13'd2) && (scan_col_reg >= 12'd2)
                      && !last_row && !last_col;

    // next scan position
    always_comb begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        if (last_col) begin
            scan_col_next = '0;
            scan_row_next = last_row ? '0 : scan_row_reg + 13'd1;
        end else begin
            scan_col_next = scan_col_reg + 12'd1;
        end
    end

    // configuration registers and scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= ses_pkg::FRAME_ROWS_RST;
            frame_cols_reg <= ses_pkg::FRAME_COLS_RST;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (ses_pkg::cfg_reg_t'(cfg_wr_index))
                    ses_pkg::REG_FRAME_ROWS: frame_rows_reg <= cfg_wr_data;
                    ses_pkg::REG_FRAME_COLS: frame_cols_reg <= cfg_wr_data[ses_pkg::COL_W-1:0];
                endcase
            end
            if (accept) begin
                scan_row_reg <= scan_row_next;
                scan_col_reg <= scan_col_next;
            end
        end
    end

    // line store read on accept
    assign rd_en   = accept && !last_col;
    assign rd_addr = ADDR_W'(scan_col_reg);

    // stage A register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pixel_reg    <= s_pixel_rgb;
            a_addr_reg     <= rd_addr;
            a_last_col_reg <= last_col;
            a_last_row_reg <= last_row;
            a_emit_reg     <= emit;
            a_interior_reg <= interior;
        end
    end

    // luma; a padding row stores nothing new and feeds zero to the window
    assign cur_luma = a_last_row_reg ? '0 : rgb_to_luma(a_pixel_reg);

    // line store update: previous row moves to two back
    assign wr_en   = commit && !a_last_col_reg;
    assign wr_data = {rd_data[LW-1:0], a_last_row_reg ? rd_data[LW-1:0] : cur_luma};

    ses_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (a_addr_reg),
        .wr_data (wr_data)
    );

    // window shift; a padding column takes no new column
    always_comb begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3 + 0] = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        if (!a_last_col_reg) begin
            win_next[2] = rd_data[2*LW-1:LW];
            win_next[5] = rd_data[LW-1:0];
            win_next[8] = cur_luma;
        end
    end

    // stage B register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            win_reg        <= win_next;
            b_emit_reg     <= a_emit_reg;
            b_interior_reg <= a_interior_reg;
            b_eor_reg      <= a_last_col_reg;
            b_eof_reg      <= a_last_col_reg && a_last_row_reg;
        end
    end

    ses_edge_calc u_edge_calc (
        .win       (win_reg),
        .interior  (b_interior_reg),
        .grade_val (grade_val)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && b_valid_reg) begin
            m_edge_reg <= grade_val;
            m_eor_reg  <= b_eor_reg;
            m_eof_reg  <= b_eof_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_edge_pixel   = {ses_pkg::ALPHA, m_edge_reg, m_edge_reg, m_edge_reg};
    assign m_end_of_row   = m_eor_reg;
    assign m_end_of_frame = m_eof_reg;

`ifndef SYNTHESIS
    // a column is never read in the cycle it is written back
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != a_addr_reg))
        else $error("line store read and write hit the same column");

    // frame end only on a row end
    a_eof_on_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_eof_reg) |-> m_eor_reg)
        else $error("end of frame without end of row");

    // thresholded edge values only
    a_edge_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_edge_reg == '0) || (m_edge_reg == ses_pkg::EDGE_MAX)
                         || ((m_edge_reg >= ses_pkg::EDGE_LO)
                             && (m_edge_reg <= ses_pkg::EDGE_HI))))
        else $error("edge value outside thresholded range");

    // an accepted word lands in stage A
    a_accept_fills_a: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> a_valid_reg)
        else $error("accepted word lost before stage A");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the Sobel edge stream unit: pixel frames against a local predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int LINE_DEPTH   = ses_pkg::DEF_MAX_COLS;
    localparam int DRAIN_SLACK  = 8;     // pipeline is three deep; a little margin
    localparam int HOLD_CYCLES  = 40;
    localparam int RANDOM_WORDS = 340;
    localparam int CALM_WORDS   = 100;
    localparam longint LIMIT_NS = 64'd8_000_000;

    localparam logic [ses_pkg::OUT_W-1:0] BORDER_WORD = {ses_pkg::ALPHA, 24'h00_0000};
    localparam logic [ses_pkg::PIX_W-1:0] BLACK = 24'h00_0000;
    localparam logic [ses_pkg::PIX_W-1:0] WHITE = 24'hFF_FFFF;
    localparam logic [ses_pkg::PIX_W-1:0] PAD   = 24'hA5_C35A;   // padding steps ignore it

    // texture amplitudes: flat, four grain sizes from fine to coarse, noise
    localparam int GRAIN [6] = '{0, 2, 6, 16, 40, 255};

    typedef struct packed {
        logic [ses_pkg::OUT_W-1:0] word;
        logic                      eor;
        logic                      eof;
    } edge_out_t;

    typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

    typedef struct packed {
        step_kind_t                     kind;
        ses_pkg::cfg_reg_t              reg_sel;
        logic [ses_pkg::CFG_DATA_W-1:0] value;
        logic [ses_pkg::PIX_W-1:0]      pixel;
        logic                           typed;
        edge_out_t                      want;
    } dir_step_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // DUT ports
    logic                           cfg_wr_en    = 1'b0;
    logic [ses_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [ses_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [ses_pkg::PIX_W-1:0]      s_pixel_rgb  = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [ses_pkg::OUT_W-1:0]      m_edge_pixel;
    logic                           m_end_of_row;
    logic                           m_end_of_frame;

    sobel_edge_stream_unit #(.MAX_COLS(LINE_DEPTH)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_rgb   (s_pixel_rgb),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_pixel  (m_edge_pixel),
        .m_end_of_row  (m_end_of_row),
        .m_end_of_frame(m_end_of_frame)
    );

    // predictor state: geometry, scan position, line stores, window
    logic [ses_pkg::ROW_W-1:0]  geo_rows = ses_pkg::FRAME_ROWS_RST;
    logic [ses_pkg::COL_W-1:0]  geo_cols = ses_pkg::FRAME_COLS_RST;
    logic [ses_pkg::ROW_W-1:0]  pos_row  = '0;
    logic [ses_pkg::COL_W-1:0]  pos_col  = '0;
    // prev row, then two back
    logic [ses_pkg::LUMA_W-1:0] line_mem [2*LINE_DEPTH] = '{default: '0};
    ses_pkg::window_t           luma_win = '0;

    edge_out_t pending_edges [$];
    int        mismatches  = 0;
    int        stream_words = 0;
    bit        calm     = 1'b0;    // no idling on either side
    bit        hold_req = 1'b0;    // ask the receiver for a long hold

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [ses_pkg::LUMA_W-1:0] luma_of(
        input logic [ses_pkg::PIX_W-1:0] rgb);
        int y;
        y = 66 * int'(rgb[23:16]) + 129 * int'(rgb[15:8]) + 25 * int'(rgb[7:0]) + 128;
        y = (y >> 8) + 16;
        return y[ses_pkg::LUMA_W-1:0];
    endfunction

    // |Gx|+|Gy| saturated, inverted, then snapped at the two thresholds
    function automatic logic [ses_pkg::LUMA_W-1:0] sobel_grade();
        int w [9];
        int k, gx, gy, mag, e;
        for (k = 0; k < 9; k++) w[k] = int'(luma_win[k]);
        gx = (w[2] - w[0]) + 2 * (w[5] - w[3]) + (w[8] - w[6]);
        gy = (w[0] + 2 * w[1] + w[2]) - (w[6] + 2 * w[7] + w[8]);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        mag = gx + gy;
        if (mag > 255) mag = 255;
        e = int'(ses_pkg::EDGE_MAX) - mag;
        if (e > int'(ses_pkg::EDGE_HI)) e = int'(ses_pkg::EDGE_MAX);
        else if (e < int'(ses_pkg::EDGE_LO)) e = 0;
        return e[ses_pkg::LUMA_W-1:0];
    endfunction

    // one scan step; returns 1 when the step produces an edge word
    function automatic bit predict_edge(input logic [ses_pkg::PIX_W-1:0] pix,
                                        output edge_out_t res);
        int rows_eff, cols_eff, row, col, r;
        bit col_end, row_end, fired;
        logic [ses_pkg::LUMA_W-1:0] above, older, fresh, grade;
        rows_eff = (geo_rows > ses_pkg::MAX_ROWS) ? int'(ses_pkg::MAX_ROWS) : int'(geo_rows);
        cols_eff = (int'(geo_cols) > LINE_DEPTH) ? LINE_DEPTH : int'(geo_cols);
        row = int'(pos_row);
        col = int'(pos_col);
        col_end = col >= cols_eff;
        row_end = row >= rows_eff;
        fired = 1'b0;
        res = '0;

        for (r = 0; r < 3; r++) begin
            luma_win[r*3 + 0] = luma_win[r*3 + 1];
            luma_win[r*3 + 1] = luma_win[r*3 + 2];
        end

        // padding column: the window shifts and takes nothing new
        if (!col_end) begin
            above = line_mem[col];
            older = line_mem[LINE_DEPTH + col];
            fresh = '0;
            line_mem[LINE_DEPTH + col] = above;
            if (!row_end) begin
                fresh = luma_of(pix);
                line_mem[col] = fresh;
            end
            luma_win[2] = older;
            luma_win[5] = above;
            luma_win[8] = fresh;
        end

        if (row > 0 && col > 0) begin
            grade = '0;
            if (row >= 2 && col >= 2 && row + 1 <= rows_eff && col + 1 <= cols_eff)
                grade = sobel_grade();
            res.word = {ses_pkg::ALPHA, grade, grade, grade};
            res.eor  = col_end;
            res.eof  = col_end && row_end;
            fired = 1'b1;
        end

        if (col_end) begin
            pos_col = '0;
            pos_row = row_end ? '0 : pos_row + 1'b1;
        end else begin
            pos_col = pos_col + 1'b1;
        end
        return fired;
    endfunction

    // random pixel around a base color, per-channel jitter of +-amp
    function automatic logic [ses_pkg::PIX_W-1:0] textured(
        input logic [ses_pkg::PIX_W-1:0] base, input int amp);
        logic [ses_pkg::PIX_W-1:0] pix;
        int ch, v;
        if (amp >= 255) return ses_pkg::PIX_W'($urandom);
        pix = '0;
        for (ch = 0; ch < 3; ch++) begin
            v = int'(base[8*ch +: 8]) + int'($urandom_range(0, 2 * amp)) - amp;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            pix[8*ch +: 8] = v[7:0];
        end
        return pix;
    endfunction

    function automatic dir_step_t cfg_step(input ses_pkg::cfg_reg_t sel,
                                           input logic [ses_pkg::CFG_DATA_W-1:0] val);
        dir_step_t s;
        s = '0;
        s.kind    = STEP_CFG;
        s.reg_sel = sel;
        s.value   = val;
        return s;
    endfunction

    function automatic dir_step_t pix_step(input logic [ses_pkg::PIX_W-1:0] pix);
        dir_step_t s;
        s = '0;
        s.kind  = STEP_PIXEL;
        s.pixel = pix;
        return s;
    endfunction

    // step whose word is known to be the plain border/zero-edge value
    function automatic dir_step_t border_step(input logic [ses_pkg::PIX_W-1:0] pix,
                                              input logic eor, input logic eof);
        dir_step_t s;
        s = pix_step(pix);
        s.typed     = 1'b1;
        s.want.word = BORDER_WORD;
        s.want.eor  = eor;
        s.want.eof  = eof;
        return s;
    endfunction

    // offer one pixel word, with an occasional gap before it
    task automatic push_pixel(input logic [ses_pkg::PIX_W-1:0] pix, input logic typed,
                              input edge_out_t want);
        edge_out_t got;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_rgb <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stream_words++;
        if (predict_edge(pix, got)) pending_edges.push_back(typed ? want : got);
    endtask

    // stop sending and wait until every expected word is out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input ses_pkg::cfg_reg_t sel,
                             input logic [ses_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= sel;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (sel == ses_pkg::REG_FRAME_ROWS) geo_rows = val;
        else geo_cols = val[ses_pkg::COL_W-1:0];
    endtask

    // feed words until the scan is back at the frame start
    task automatic run_frame(input int amp);
        logic [ses_pkg::PIX_W-1:0] base;
        base = ses_pkg::PIX_W'($urandom);
        do push_pixel(textured(base, amp), 1'b0, '0);
        while (pos_row != '0 || pos_col != '0);
    endtask

    // half the time a fresh small geometry, otherwise frames run back to back
    task automatic reshape_frame();
        int rows, cols;
        if ($urandom_range(0, 1) == 0) return;
        rows = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        cols = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
        write_reg(ses_pkg::REG_FRAME_ROWS, ses_pkg::CFG_DATA_W'(rows));
        write_reg(ses_pkg::REG_FRAME_COLS, ses_pkg::CFG_DATA_W'(cols));
    endtask

    // result side: check accepted words, random stalls, long hold on request
    initial begin : result_side
        int stall_left, hold_left;
        edge_out_t want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                if (pending_edges.size() == 0) begin
                    flag_mismatch($sformatf("edge word %h with nothing expected", m_edge_pixel));
                end else begin
                    want = pending_edges.pop_front();
                    if (m_edge_pixel !== want.word)
                        flag_mismatch($sformatf("edge word %h, expected %h",
                                                m_edge_pixel, want.word));
                    if (m_end_of_row !== want.eor)
                        flag_mismatch($sformatf("end_of_row %b, expected %b",
                                                m_end_of_row, want.eor));
                    if (m_end_of_frame !== want.eof)
                        flag_mismatch($sformatf("end_of_frame %b, expected %b",
                                                m_end_of_frame, want.eof));
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : pixel_side
        dir_step_t script [26];
        int frame_no, base_words;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // a few words under the reset geometry, then shrink the frame under the
        // scan so both bounds are crossed mid-frame
        repeat (5) push_pixel(ses_pkg::PIX_W'($urandom), 1'b0, '0);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'd3);
        repeat (6) push_pixel(ses_pkg::PIX_W'($urandom), 1'b0, '0);
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd1);
        run_frame(255);

        // directed: 3x3 frame with a black left column (saturated edge), then
        // the 1x2 frame where row and frame end fall on the same word
        script = '{
            cfg_step(ses_pkg::REG_FRAME_ROWS, 13'd3), cfg_step(ses_pkg::REG_FRAME_COLS, 13'd3),
            pix_step(BLACK), pix_step(WHITE), pix_step(WHITE), pix_step(PAD),
            pix_step(BLACK), border_step(WHITE, 1'b0, 1'b0),
            border_step(WHITE, 1'b0, 1'b0), border_step(PAD, 1'b1, 1'b0),
            pix_step(BLACK), border_step(WHITE, 1'b0, 1'b0),
            border_step(WHITE, 1'b0, 1'b0), border_step(PAD, 1'b1, 1'b0),
            pix_step(PAD), border_step(PAD, 1'b0, 1'b0),
            border_step(PAD, 1'b0, 1'b0), border_step(PAD, 1'b1, 1'b1),
            cfg_step(ses_pkg::REG_FRAME_ROWS, 13'd1), cfg_step(ses_pkg::REG_FRAME_COLS, 13'd2),
            pix_step(WHITE), pix_step(BLACK), pix_step(PAD),
            pix_step(PAD), border_step(PAD, 1'b0, 1'b0), border_step(PAD, 1'b1, 1'b1)
        };
        foreach (script[i]) begin
            if (script[i].kind == STEP_CFG) write_reg(script[i].reg_sel, script[i].value);
            else push_pixel(script[i].pixel, script[i].typed, script[i].want);
        end

        // random small frames with varied texture
        base_words = stream_words;
        frame_no = 0;
        while (stream_words - base_words < RANDOM_WORDS) begin
            reshape_frame();
            if (frame_no % 5 == 2) hold_req = 1'b1;
            run_frame(GRAIN[$urandom_range(0, 5)]);
            frame_no++;
        end

        // zero sizes: nothing comes out, the scan still wraps
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd3);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'd0);
        run_frame(255);
        run_frame(255);
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd0);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'd5);
        run_frame(255);
        run_frame(255);
        // smallest frame, then bit 12 of the column value dropped, under a long hold
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd1);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'd1);
        run_frame(255);
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd3);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'h1003);
        hold_req = 1'b1;
        run_frame(16);
        // oversized registers: scan a short stretch, then shrink the frame under it
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'h1FFF);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'h1FFF);
        repeat (8) push_pixel(ses_pkg::PIX_W'($urandom), 1'b0, '0);
        write_reg(ses_pkg::REG_FRAME_COLS, 13'd3);
        push_pixel(ses_pkg::PIX_W'($urandom), 1'b0, '0);
        write_reg(ses_pkg::REG_FRAME_ROWS, 13'd1);
        run_frame(255);

        // closing stretch at full rate on both sides
        drain_results();
        calm = 1'b1;
        base_words = stream_words;
        while (stream_words - base_words < CALM_WORDS) begin
            reshape_frame();
            run_frame(GRAIN[$urandom_range(0, 5)]);
        end

        drain_results();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
